// ===== rtl/core/int_to_ascii_padded_defines.svh =====
// Assertion macros shared by the formatter RTL.
// Each check is sampled on aclk and switched off while aresetn is low.
`ifndef INT_TO_ASCII_PADDED_DEFINES_SVH
`define INT_TO_ASCII_PADDED_DEFINES_SVH
`ifndef SYNTHESIS
`define ITA_NEVER(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("ita: forbidden condition seen");
`define ITA_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ita: expected follow-up missing");
`else
`define ITA_NEVER(lbl, expr)
`define ITA_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/ita_pkg.sv =====
`default_nettype none

package ita_pkg;

    localparam int DEFAULT_MAX_WIDTH = 31;

    localparam int DIGITS   = 10;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int VALUE_W  = 32;
    localparam int CNT_W    = 6;
    localparam int STEP_W   = 3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_HEXA  = 8'h57;  // 'a' - 10
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] OPC_UDEC = 2'd0;
    localparam logic [1:0] OPC_SDEC = 2'd1;

    // Micro-operations
    localparam logic [2:0] ACT_NOP   = 3'd0;
    localparam logic [2:0] ACT_LOAD  = 3'd1;
    localparam logic [2:0] ACT_SHIFT = 3'd2;
    localparam logic [2:0] ACT_MEAS  = 3'd3;
    localparam logic [2:0] ACT_PAD   = 3'd4;
    localparam logic [2:0] ACT_SIGN  = 3'd5;
    localparam logic [2:0] ACT_DIGIT = 3'd6;

    // Jump conditions
    localparam logic [2:0] COND_NEVER    = 3'd0;
    localparam logic [2:0] COND_NO_REQ   = 3'd1;
    localparam logic [2:0] COND_HEX      = 3'd2;
    localparam logic [2:0] COND_CNT_ZERO = 3'd3;
    localparam logic [2:0] COND_PAD_ZERO = 3'd4;
    localparam logic [2:0] COND_NOT_NEG  = 3'd5;
    localparam logic [2:0] COND_DIG_ZERO = 3'd6;

    // Program steps
    localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SKIP  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_CONV  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_MEAS  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_PAD   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_SIGN  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_DIGIT = 3'd6;

    typedef struct packed {
        logic [2:0]        act;
        logic [2:0]        cond;
        logic [STEP_W-1:0] tgt;
        logic              loop;
    } ctrl_word_t;

    typedef struct packed {
        logic load;
        logic shift;
    } bcd_ctl_t;

    typedef struct packed {
        logic       cnt_zero;
        logic       neg;
        logic [3:0] ndig;
    } bcd_stat_t;

    // Control store: when the condition holds jump to tgt and skip the action,
    // otherwise run the action and either stay (loop) or fall through.
    function automatic ctrl_word_t rom_word(input logic [STEP_W-1:0] pc);
        ctrl_word_t w;
        unique case (pc)
            STEP_WAIT:  w = '{ACT_LOAD,  COND_NO_REQ,   STEP_WAIT,  1'b0};
            STEP_SKIP:  w = '{ACT_NOP,   COND_HEX,      STEP_MEAS,  1'b0};
            STEP_CONV:  w = '{ACT_SHIFT, COND_CNT_ZERO, STEP_MEAS,  1'b1};
            STEP_MEAS:  w = '{ACT_MEAS,  COND_NEVER,    STEP_WAIT,  1'b0};
            STEP_PAD:   w = '{ACT_PAD,   COND_PAD_ZERO, STEP_SIGN,  1'b1};
            STEP_SIGN:  w = '{ACT_SIGN,  COND_NOT_NEG,  STEP_DIGIT, 1'b0};
            STEP_DIGIT: w = '{ACT_DIGIT, COND_DIG_ZERO, STEP_WAIT,  1'b1};
            default:    w = '{ACT_NOP,   COND_NEVER,    STEP_WAIT,  1'b0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/int_to_ascii_padded.sv =====
// Sequence: after acceptance a hex request goes straight to measuring, while a decimal one
// first runs the shift-add-3 converter; pad characters, an optional minus and the digits follow.
// One request is handled at a time: a new one is taken only back in the wait step, and the
// emission steps stall while the output register holds a character the consumer has not taken.
// Reset: synchronous, active-low aresetn; returns the sequencer to its wait step and
// empties the output register.
`default_nettype none

`include "int_to_ascii_padded_defines.svh"

module int_to_ascii_padded
    import ita_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_value,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [4:0]  s_min_width,
    input  wire logic        s_zero_pad,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_char_out,
    output logic             m_last
);

    // Field width cap; min_width is only 5 bits, so a cap of 31 or more never bites
    localparam logic [6:0] CAP = 7'(MAX_WIDTH);

    // Sequencer state: step counter and the control word it addresses
    logic [STEP_W-1:0] pc_reg, pc_next;
    ctrl_word_t        cw;

    // Request fields held for the whole conversion
    logic              hex_reg;
    logic [7:0]        fill_reg;
    logic [4:0]        wid_reg;
    logic [4:0]        wid_cap;

    // Emission counters
    logic [4:0]        pad_reg, pad_next;
    logic [3:0]        dig_left_reg, dig_left_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_char_reg, m_char_next;
    logic              m_last_reg, m_last_next;

    // Converter interface
    bcd_ctl_t          bctl;
    bcd_stat_t         bstat;
    logic [BCD_W-1:0]  digits;

    logic              cond_true;
    logic              is_emit;
    logic              out_free;
    logic              stall;
    logic              run;
    logic [3:0]        len;
    logic [3:0]        dig_idx;
    logic [3:0]        dig;

    ita_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (bctl),
        .value   (s_value),
        .opcode  (s_opcode),
        .digits  (digits),
        .stat    (bstat)
    );

    assign cw = rom_word(pc_reg);

    // Evaluate the jump condition of the current step
    always_comb begin
        unique case (cw.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_NO_REQ:   cond_true = !s_valid;
            COND_HEX:      cond_true = hex_reg;
            COND_CNT_ZERO: cond_true = bstat.cnt_zero;
            COND_PAD_ZERO: cond_true = (pad_reg == '0);
            COND_NOT_NEG:  cond_true = !bstat.neg;
            COND_DIG_ZERO: cond_true = (dig_left_reg == '0);
            default:       cond_true = 1'b0;
        endcase
    end

    assign is_emit  = (cw.act == ACT_PAD) || (cw.act == ACT_SIGN) || (cw.act == ACT_DIGIT);
    assign out_free = !m_valid_reg || m_ready;
    // Hold the step while a character waits for a full output register
    assign stall    = !cond_true && is_emit && !out_free;
    assign run      = !cond_true && !stall;

    always_comb begin
        if (stall) begin
            pc_next = pc_reg;
        end else if (cond_true) begin
            pc_next = cw.tgt;
        end else if (cw.loop) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    // Accept a request only in the wait step
    assign s_ready    = (cw.act == ACT_LOAD);
    assign bctl.load  = run && (cw.act == ACT_LOAD);
    assign bctl.shift = run && (cw.act == ACT_SHIFT);

    assign wid_cap = ({2'b00, s_min_width} > CAP) ? CAP[4:0] : s_min_width;

    // Text length is the digit count plus the sign
    assign len     = bstat.ndig + {3'b000, bstat.neg};
    assign dig_idx = dig_left_reg - 1'b1;
    assign dig     = digits[{dig_idx, 2'b00} +: 4];

    always_comb begin
        pad_next      = pad_reg;
        dig_left_next = dig_left_reg;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        if (run) begin
            case (cw.act)
                ACT_MEAS: begin
                    pad_next      = (wid_reg > {1'b0, len}) ? wid_reg - {1'b0, len} : '0;
                    dig_left_next = bstat.ndig;
                end
                ACT_PAD: begin
                    pad_next     = pad_reg - 1'b1;
                    m_char_next  = fill_reg;
                    m_last_next  = 1'b0;
                    m_valid_next = 1'b1;
                end
                ACT_SIGN: begin
                    m_char_next  = CH_MINUS;
                    m_last_next  = 1'b0;
                    m_valid_next = 1'b1;
                end
                ACT_DIGIT: begin
                    dig_left_next = dig_left_reg - 1'b1;
                    m_char_next   = (dig < 4'd10) ? CH_ZERO + {4'h0, dig}
                                                  : CH_HEXA + {4'h0, dig};
                    m_last_next   = (dig_left_reg == 4'd1);
                    m_valid_next  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= STEP_WAIT;
            m_valid_reg  <= 1'b0;
            pad_reg      <= '0;
            dig_left_reg <= '0;
        end else begin
            pc_reg       <= pc_next;
            m_valid_reg  <= m_valid_next;
            pad_reg      <= pad_next;
            dig_left_reg <= dig_left_next;
        end
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        if (bctl.load) begin
            hex_reg  <= s_opcode[1];
            fill_reg <= s_zero_pad ? CH_ZERO : CH_SPACE;
            wid_reg  <= wid_cap;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_char_out = m_char_reg;
    assign m_last     = m_last_reg;

    // An accepted request always moves on to the format check
    `ITA_NEXT(a_load_advances, s_valid && s_ready, pc_reg == STEP_SKIP)
    // Measuring always leaves at least one digit to send
    `ITA_NEXT(a_meas_digits, pc_reg == STEP_MEAS, dig_left_reg != '0)
    // A new request never starts while a non-final character is still pending
    `ITA_NEVER(a_no_overlap, s_ready && m_valid_reg && !m_last_reg)

endmodule

`default_nettype wire

// ===== rtl/core/ita_bcd.sv =====
`default_nettype none

// Magnitude register and shift-add-3 converter, one bit per shift.
module ita_bcd
    import ita_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bcd_ctl_t           ctl,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [1:0]         opcode,
    output logic      [BCD_W-1:0]   digits,
    output bcd_stat_t               stat
);

    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next, bcd_adj;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic               load_neg;
    logic [3:0]         ndig;

    assign load_neg = (opcode == OPC_SDEC) && value[VALUE_W-1];

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    always_comb begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        if (ctl.load) begin
            neg_next = load_neg;
            mag_next = load_neg ? (~value + 1'b1) : value;
            bcd_next = opcode[1] ? {{(BCD_W-VALUE_W){1'b0}}, value} : '0;
            cnt_next = CNT_W'(VALUE_W);
        end else if (ctl.shift) begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
            mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    // Count significant digits, at least one
    always_comb begin
        ndig = 4'd1;
        for (int i = 1; i < DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                ndig = 4'(i + 1);
            end
        end
    end

    assign digits        = bcd_reg;
    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.neg      = neg_reg;
    assign stat.ndig     = ndig;

endmodule

`default_nettype wire
